### rtl/core/assert_macros.svh
// assertion macros shared by the rtl in this folder
// used by circle_window_span; expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define CWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge outside reset
`define CWS_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### rtl/core/cws_pkg.sv
// types, register indexes and the square root step for circle_window_span
// no dependencies
package cws_pkg;

  localparam int NUM_STAGES = 7;
  localparam int SQRT_STAGES = 4;

  localparam logic [2:0] REG_FIRST_LINE = 3'd0;
  localparam logic [2:0] REG_END_LINE   = 3'd1;
  localparam logic [2:0] REG_CENTER_X   = 3'd2;
  localparam logic [2:0] REG_CENTER_Y   = 3'd3;
  localparam logic [2:0] REG_RADIUS     = 3'd4;

  // front stage: span flag and distance from the center line
  typedef struct packed {
    logic       span;
    logic [7:0] ady;
  } front_t;

  // square root stages: operand, partial remainder and partial root
  typedef struct packed {
    logic        span;
    logic [15:0] val;
    logic [9:0]  rem;
    logic [7:0]  root;
  } sqrt_t;

  // one digit of the restoring square root, two operand bits in
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    sqrt_t      o;
    logic [11:0] rem_sh;
    logic [11:0] trial;
    o = s;
    rem_sh = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem = 10'(rem_sh - trial);
      o.root = {s.root[6:0], 1'b1};
    end else begin
      o.rem = rem_sh[9:0];
      o.root = {s.root[6:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### rtl/core/circle_window_span.sv
// circle_window_span: left and right window edges of a filled circle per scanline
// uses cws_pkg and assert_macros.svh
//
// One scanline is taken per clock when the output side keeps up. Stage one
// checks the line against the requested range and the circle's vertical
// extent and forms |dy|, stage two forms radius^2 - dy^2 as one
// (r - |dy|) * (r + |dy|) product, four stages each resolve two bits of the
// floor square root, and the last stage adds and subtracts the half-width
// around center_x with clamping to 0..SCREEN_WIDTH. Lines outside the span
// give in_span 0 and both edges 0. Each stage holds only while the stage
// after it is full and stalled, so bubbles close up.
// Registers are written through the cfg port, which is always ready, and
// should be changed only while no item is in flight.
`include "assert_macros.svh"

module circle_window_span #(
  parameter int SCREEN_WIDTH = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_scanline,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_in_span,
  output logic [7:0]  out_right_edge,
  output logic [7:0]  out_left_edge
);

  localparam logic signed [11:0] SW_EDGE = 12'(SCREEN_WIDTH);

  logic [7:0]         first_line_r;
  logic [7:0]         end_line_r;
  logic signed [10:0] center_x_r;
  logic signed [10:0] center_y_r;
  logic [7:0]         radius_r;

  logic [cws_pkg::NUM_STAGES-1:0] vld_r;
  logic [cws_pkg::NUM_STAGES-1:0] rdy;

  cws_pkg::front_t front_r, front_nxt;
  cws_pkg::sqrt_t  sq_r [cws_pkg::SQRT_STAGES+1];
  cws_pkg::sqrt_t  sq_nxt [cws_pkg::SQRT_STAGES+1];
  logic            span_r;
  logic [7:0]      right_r, left_r;
  logic [7:0]      right_nxt, left_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= '0;
      end_line_r <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cws_pkg::REG_FIRST_LINE: first_line_r <= cfg_data[7:0];
        cws_pkg::REG_END_LINE:   end_line_r <= cfg_data[7:0];
        cws_pkg::REG_CENTER_X:   center_x_r <= $signed(cfg_data);
        cws_pkg::REG_CENTER_Y:   center_y_r <= $signed(cfg_data);
        cws_pkg::REG_RADIUS:     radius_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[cws_pkg::NUM_STAGES-1] = !vld_r[cws_pkg::NUM_STAGES-1] || out_ready;
    for (int k = cws_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < cws_pkg::NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: range test and |dy|
  always_comb begin
    logic signed [11:0] dy;
    logic signed [11:0] rad;
    logic signed [11:0] ady;
    dy = $signed({4'b0000, in_scanline}) - $signed({center_y_r[10], center_y_r});
    rad = $signed({4'b0000, radius_r});
    ady = (dy < 0) ? -dy : dy;
    front_nxt.span = (in_scanline >= first_line_r) && (in_scanline < end_line_r) &&
                     (dy >= -rad) && (dy < rad);
    front_nxt.ady = ady[7:0];
  end

  // stage 1: r^2 - dy^2 as one product; stages 2..5: two root bits each
  always_comb begin
    logic [16:0] prod;
    prod = 17'({1'b0, radius_r - front_r.ady}) * 17'({1'b0, radius_r} + {1'b0, front_r.ady});
    sq_nxt[0].span = front_r.span;
    sq_nxt[0].val = prod[15:0];
    sq_nxt[0].rem = '0;
    sq_nxt[0].root = '0;
    for (int s = 0; s < cws_pkg::SQRT_STAGES; s++) begin
      sq_nxt[s+1] = cws_pkg::sqrt_step(
        cws_pkg::sqrt_step(sq_r[s], sq_r[s].val[15-4*s -: 2]),
        sq_r[s].val[13-4*s -: 2]);
    end
  end

  // last stage: edges around center_x, clamped
  always_comb begin
    logic signed [11:0] cx;
    logic signed [11:0] hw;
    logic signed [11:0] rsum;
    logic signed [11:0] lsum;
    logic signed [11:0] rcl;
    logic signed [11:0] lcl;
    cx = $signed({center_x_r[10], center_x_r});
    hw = $signed({4'b0000, sq_r[cws_pkg::SQRT_STAGES].root});
    rsum = cx + hw;
    lsum = cx - hw;
    rcl = (rsum < 0) ? 12'sd0 : ((rsum > SW_EDGE) ? SW_EDGE : rsum);
    lcl = (lsum < 0) ? 12'sd0 : ((lsum > SW_EDGE) ? SW_EDGE : lsum);
    right_nxt = sq_r[cws_pkg::SQRT_STAGES].span ? rcl[7:0] : 8'd0;
    left_nxt = sq_r[cws_pkg::SQRT_STAGES].span ? lcl[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      front_r <= front_nxt;
    end
    for (int s = 0; s <= cws_pkg::SQRT_STAGES; s++) begin
      if (rdy[s+1]) begin
        sq_r[s] <= sq_nxt[s];
      end
    end
    if (rdy[cws_pkg::NUM_STAGES-1]) begin
      span_r <= sq_r[cws_pkg::SQRT_STAGES].span;
      right_r <= right_nxt;
      left_r <= left_nxt;
    end
  end

  assign out_valid = vld_r[cws_pkg::NUM_STAGES-1];
  assign out_in_span = span_r;
  assign out_right_edge = right_r;
  assign out_left_edge = left_r;

  `CWS_ASSERT_IMP(a_off_span_zero, out_valid && !out_in_span,
    (out_left_edge == 8'd0) && (out_right_edge == 8'd0), "edges set off span")
  `CWS_ASSERT_IMP(a_edge_order, (SCREEN_WIDTH < 256) && out_valid && out_in_span,
    out_left_edge <= out_right_edge, "left edge right of right edge")
  `CWS_ASSERT_IMP(a_stall_full, !in_ready,
    &vld_r, "input stalled with a free stage")
  `CWS_ASSERT(a_accept_enters, (in_valid && in_ready) |=> vld_r[0],
    "transfer did not enter the pipe")

endmodule
